[rtl/core/calf_pkg.sv]
// Package with types, constants and reset table contents for the card access lockout block.
package calf_pkg;

    localparam int TABLE_SLOTS_DEF   = 16;
    localparam int UID_MAX_BYTES_DEF = 10;

    localparam logic [3:0]  FAIL_LIMIT_RST   = 4'd3;
    localparam logic [15:0] LOCKOUT_TIME_RST = 16'd5000;
    localparam logic [15:0] HOLD_TIME_RST    = 16'd500;
    localparam logic [3:0]  CONFIRM_RST      = 4'd3;

    localparam logic [63:0] CARD0_UID = 64'h0000_0000_0724_b886;
    localparam logic [63:0] CARD1_UID = 64'h0000_0000_0724_da52;

    localparam logic [2:0] CFG_FAIL_LIMIT   = 3'd0;
    localparam logic [2:0] CFG_LOCKOUT_TIME = 3'd1;
    localparam logic [2:0] CFG_SUCCESS_HOLD = 3'd2;
    localparam logic [2:0] CFG_FAIL_HOLD    = 3'd3;
    localparam logic [2:0] CFG_CONFIRM      = 3'd4;
    localparam logic [2:0] CFG_READER_READY = 3'd5;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_SUCCESS = 2'd1,
        EV_FAIL    = 2'd2,
        EV_LOCKOUT = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE        = 3'd0,
        ST_POLL        = 3'd1,
        ST_VERIFY      = 3'd2,
        ST_OK_FB       = 3'd3,
        ST_FAIL_FB     = 3'd4,
        ST_WAIT_REMOVE = 3'd5,
        ST_LOCK        = 3'd6
    } t_state;

    typedef enum logic [2:0] {
        SQ_IDLE   = 3'd0,
        SQ_SEARCH = 3'd1,
        SQ_FREE   = 3'd2,
        SQ_FIN    = 3'd3,
        SQ_OUT    = 3'd4
    } t_seq;

    typedef struct packed {
        logic [31:0] now_time;
        logic        enable;
        logic        register_request;
        logic        card_ok;
        logic [3:0]  card_uid_size;
        logic [63:0] card_uid_low;
        logic [15:0] card_uid_high;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_code;
        logic        uid_present;
        logic [4:0]  slot_index;
        logic [3:0]  out_uid_size;
        logic [63:0] out_uid_low;
        logic [15:0] out_uid_high;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic clear;
    } t_cmp_ctl;

endpackage

[rtl/core/calf_uid_cmp.sv]
// Byte-serial comparator of a stored UID against the polled UID.
module calf_uid_cmp #(
    parameter int UID_MAX_BYTES = calf_pkg::UID_MAX_BYTES_DEF
) (
    input  logic                   i_clk,
    input  calf_pkg::t_cmp_ctl     i_ctl,
    input  logic [79:0]            i_a,
    input  logic [79:0]            i_b,
    input  logic [3:0]             i_size,
    output logic                   o_done,
    output logic                   o_equal
);
    import calf_pkg::*;

    localparam logic [3:0] MAXB = 4'(UID_MAX_BYTES);

    logic [79:0] r_a, r_b;
    logic [3:0]  r_left;
    logic        r_eq, r_busy;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_left <= (i_size < MAXB) ? i_size : MAXB;
            r_eq   <= 1'b1;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_left == 4'd0) begin
                r_busy <= 1'b0;
            end else begin
                if (r_a[7:0] != r_b[7:0]) begin
                    r_eq <= 1'b0;
                end
                r_a    <= {8'd0, r_a[79:8]};
                r_b    <= {8'd0, r_b[79:8]};
                r_left <= r_left - 4'd1;
            end
        end
    end

    assign o_done  = r_busy && (r_left == 4'd0);
    assign o_equal = r_eq;
endmodule

[rtl/core/card_access_lockout_fsm.sv]
// Top level of the card access controller with failure lockout.
// One item is in flight at a time; the next item can be taken in the cycle after the result item leaves.
// A poll outside verify hands its result over through SQ_OUT. Verify reads each slot in turn and
// byte-compares it on a size match, then, for an unknown card in register mode, scans for a free
// slot, and hands its result over through SQ_FIN.
// Synchronous active-low reset restores the registers, the two preloaded cards and idle.
module card_access_lockout_fsm #(
    parameter int TABLE_SLOTS   = calf_pkg::TABLE_SLOTS_DEF,
    parameter int UID_MAX_BYTES = calf_pkg::UID_MAX_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  calf_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output calf_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import calf_pkg::*;

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [SW:0] LAST = (SW+1)'(TABLE_SLOTS - 1);

    // Configuration registers.
    logic [3:0]  r_fail_limit, r_confirm;
    logic [15:0] r_lock_time, r_ok_hold, r_fail_hold;
    logic        r_ready;

    // Controller state.
    t_state      r_st;
    logic [3:0]  r_det, r_fail;
    logic [31:0] r_fb_dl, r_lk_dl;

    // Table: valid bits in flops, entries in a memory with a registered read.
    // Entries never written read back only behind a clear valid bit.
    logic [TABLE_SLOTS-1:0] r_used;
    logic [83:0] mem [TABLE_SLOTS];
    logic [83:0] r_rd;

    // Sequencer.
    t_seq        r_sq, n_sq;
    t_in_item    r_in;
    logic [SW:0] r_k;
    logic        r_found, r_rdv, r_wait;
    logic [SW-1:0] r_hit;
    t_out_item   r_out;
    logic        r_ov;

    t_cmp_ctl    cmp_ctl;
    logic        cmp_done, cmp_eq;

    assign o_stall     = (r_sq != SQ_IDLE) || r_ov;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ov;
    assign o_item      = r_out;

    wire accept = i_valid && !o_stall;

    // Slot entry read address walks with r_k; r_rdv marks r_rd as that slot's data.
    wire slot_hit_size = r_used[r_k[SW-1:0]] && (r_rd[83:80] == r_in.card_uid_size);
    assign cmp_ctl.start = (r_sq == SQ_SEARCH) && r_rdv && !r_wait && slot_hit_size;
    assign cmp_ctl.clear = !i_rst_n;

    calf_uid_cmp #(.UID_MAX_BYTES(UID_MAX_BYTES)) u_cmp (
        .i_clk  (i_clk),
        .i_ctl  (cmp_ctl),
        .i_a    (r_rd[79:0]),
        .i_b    ({r_in.card_uid_high, r_in.card_uid_low}),
        .i_size (r_in.card_uid_size),
        .o_done (cmp_done),
        .o_equal(cmp_eq)
    );

    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_k[SW-1:0]];
        if (!i_rst_n) begin
            mem[0] <= {4'd4, 16'd0, CARD0_UID};
            mem[1] <= {4'd4, 16'd0, CARD1_UID};
        end else if (r_sq == SQ_FIN && !r_found && r_in.register_request && !r_k[SW]) begin
            mem[r_k[SW-1:0]] <= {r_in.card_uid_size, r_in.card_uid_high, r_in.card_uid_low};
        end
    end

    // Next sequencer step.
    always_comb begin
        n_sq = r_sq;
        unique case (r_sq)
            SQ_IDLE: begin
                if (accept) begin
                    if (r_ready && i_item.enable && r_st == ST_VERIFY && i_item.card_ok) begin
                        n_sq = SQ_SEARCH;
                    end else begin
                        n_sq = SQ_OUT;
                    end
                end
            end
            SQ_SEARCH: begin
                if (r_found || r_k > LAST) begin
                    n_sq = (!r_found && r_in.register_request) ? SQ_FREE : SQ_FIN;
                end
            end
            SQ_FREE: begin
                if (r_k > LAST || !r_used[r_k[SW-1:0]]) begin
                    n_sq = SQ_FIN;
                end
            end
            SQ_FIN:  n_sq = SQ_IDLE;
            SQ_OUT:  n_sq = SQ_IDLE;
            default: n_sq = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_limit <= FAIL_LIMIT_RST;
            r_lock_time  <= LOCKOUT_TIME_RST;
            r_ok_hold    <= HOLD_TIME_RST;
            r_fail_hold  <= HOLD_TIME_RST;
            r_confirm    <= CONFIRM_RST;
            r_ready      <= 1'b1;
            r_st   <= ST_IDLE;
            r_det  <= 4'd0;
            r_fail <= 4'd0;
            r_fb_dl <= 32'd0;
            r_lk_dl <= 32'd0;
            r_used <= TABLE_SLOTS'(2'b11);
            r_sq  <= SQ_IDLE;
            r_ov  <= 1'b0;
            r_k   <= '0;
            r_rdv <= 1'b0;
            r_wait <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FAIL_LIMIT:   r_fail_limit <= i_cfg_data[3:0];
                    CFG_LOCKOUT_TIME: r_lock_time  <= i_cfg_data;
                    CFG_SUCCESS_HOLD: r_ok_hold    <= i_cfg_data;
                    CFG_FAIL_HOLD:    r_fail_hold  <= i_cfg_data;
                    CFG_CONFIRM:      r_confirm    <= i_cfg_data[3:0];
                    CFG_READER_READY: r_ready      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            r_sq <= n_sq;
            unique case (r_sq)
                SQ_IDLE: begin
                    if (accept) begin
                        r_in  <= i_item;
                        r_k   <= '0;
                        r_rdv <= 1'b0;
                        r_wait <= 1'b0;
                        r_found <= 1'b0;
                    end
                end
                SQ_SEARCH: begin
                    // A slot first waits for its registered read, then takes a byte compare if sizes match.
                    if (!r_found && r_k <= LAST) begin
                        if (!r_rdv) begin
                            r_rdv <= 1'b1;
                        end else if (cmp_ctl.start) begin
                            r_wait <= 1'b1;
                        end else if (r_wait) begin
                            if (cmp_done) begin
                                r_wait <= 1'b0;
                                if (cmp_eq) begin
                                    r_found <= 1'b1;
                                    r_hit   <= r_k[SW-1:0];
                                end else begin
                                    r_k <= r_k + 1'b1;
                                    r_rdv <= 1'b0;
                                end
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_rdv <= 1'b0;
                        end
                    end else if (n_sq == SQ_FREE) begin
                        r_k <= '0;
                    end
                end
                SQ_FREE: begin
                    if (n_sq == SQ_SEARCH || n_sq == SQ_FREE) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                SQ_FIN: begin
                    // Verify outcome.
                    r_ov <= 1'b1;
                    r_out.uid_present  <= 1'b1;
                    r_out.out_uid_size <= r_in.card_uid_size;
                    r_out.out_uid_low  <= r_in.card_uid_low;
                    r_out.out_uid_high <= r_in.card_uid_high;
                    if (r_found || (r_in.register_request && !r_k[SW])) begin
                        if (!r_found) begin
                            r_used[r_k[SW-1:0]] <= 1'b1;
                        end
                        r_fail <= 4'd0;
                        r_st   <= ST_OK_FB;
                        r_fb_dl <= r_in.now_time + {16'd0, r_ok_hold};
                        r_out.event_code <= EV_SUCCESS;
                        r_out.slot_index <= r_found ? 5'({1'b0, r_hit})
                                                    : 5'(r_k[SW-1:0]);
                    end else begin
                        r_out.slot_index <= 5'h1f;
                        if (((r_fail < 4'd15) ? r_fail + 4'd1 : r_fail) >= r_fail_limit) begin
                            r_st <= ST_LOCK;
                            r_fb_dl <= r_in.now_time;
                            r_lk_dl <= r_in.now_time + {16'd0, r_lock_time};
                            r_out.event_code <= EV_LOCKOUT;
                        end else begin
                            r_st <= ST_FAIL_FB;
                            r_fb_dl <= r_in.now_time + {16'd0, r_fail_hold};
                            r_out.event_code <= EV_FAIL;
                        end
                        if (r_fail < 4'd15) begin
                            r_fail <= r_fail + 4'd1;
                        end
                    end
                end
                SQ_OUT: begin
                    // Every poll that needs no table search.
                    r_ov <= 1'b1;
                    r_out <= '{EV_NONE, 1'b0, 5'h1f, 4'd0, 64'd0, 16'd0};
                    if (r_ready) begin
                        if (!r_in.enable && r_st != ST_IDLE) begin
                            r_st <= ST_IDLE;
                            r_det <= 4'd0;
                            r_fail <= 4'd0;
                            r_fb_dl <= r_in.now_time;
                            r_lk_dl <= r_in.now_time;
                        end else begin
                            unique case (r_st)
                                ST_IDLE: begin
                                    if (r_in.enable) begin
                                        r_det <= 4'd0;
                                        r_st <= ST_POLL;
                                        r_fb_dl <= r_in.now_time;
                                    end
                                end
                                ST_POLL: begin
                                    if (r_in.card_ok) begin
                                        if (((r_det < 4'd15) ? r_det + 4'd1 : r_det)
                                            >= r_confirm) begin
                                            r_det <= 4'd0;
                                            r_st <= ST_VERIFY;
                                            r_fb_dl <= r_in.now_time;
                                        end else if (r_det < 4'd15) begin
                                            r_det <= r_det + 4'd1;
                                        end
                                    end else begin
                                        r_det <= 4'd0;
                                    end
                                end
                                ST_VERIFY: begin
                                    r_st <= ST_POLL;
                                    r_fb_dl <= r_in.now_time;
                                end
                                ST_OK_FB, ST_FAIL_FB: begin
                                    if (r_in.now_time >= r_fb_dl) begin
                                        r_st <= ST_WAIT_REMOVE;
                                        r_fb_dl <= r_in.now_time;
                                    end
                                end
                                ST_WAIT_REMOVE: begin
                                    if (!r_in.card_ok) begin
                                        r_det <= 4'd0;
                                        r_st <= ST_POLL;
                                        r_fb_dl <= r_in.now_time;
                                    end
                                end
                                ST_LOCK: begin
                                    if (r_in.now_time >= r_lk_dl) begin
                                        r_fail <= 4'd0;
                                        r_det <= 4'd0;
                                        r_st <= ST_POLL;
                                        r_fb_dl <= r_in.now_time;
                                    end
                                end
                                default: begin
                                    r_st <= ST_IDLE;
                                    r_det <= 4'd0;
                                    r_fail <= 4'd0;
                                    r_fb_dl <= r_in.now_time;
                                    r_lk_dl <= r_in.now_time;
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[tb/sv/tb_card_access_lockout_fsm.sv]
// Self-checking testbench for the card access lockout controller.
`timescale 1ns / 100ps

module tb_card_access_lockout_fsm;
    import calf_pkg::*;

    // The clock, reset and all ports of the block under test.
    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    card_access_lockout_fsm dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // The clock runs with a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Our own copy of the controller: its settings, its state and its card table.
    logic [3:0]  fail_limit_q;
    logic [15:0] lockout_time_q;
    logic [15:0] success_hold_q;
    logic [15:0] fail_hold_q;
    logic [3:0]  confirm_q;
    logic        reader_ready_q;

    t_state      state_q;
    logic [3:0]  detect_cnt;
    logic [3:0]  failure_cnt;
    logic [31:0] feedback_dl;
    logic [31:0] lockout_dl;
    logic        card_used [16];
    logic [3:0]  card_size [16];
    logic [63:0] card_low  [16];
    logic [15:0] card_high [16];

    // Items waiting to be driven, and the poll results still to come back.
    t_in_item  poll_queue[$];
    t_out_item expected_events[$];

    int  mismatches;
    int  polls_sent;
    int  events_seen;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  watchdog_hit;
    logic in_taken;

    // The reset contents: the two preloaded cards, the default settings, idle.
    task automatic model_reset();
        int k;
        fail_limit_q   = FAIL_LIMIT_RST;
        lockout_time_q = LOCKOUT_TIME_RST;
        success_hold_q = HOLD_TIME_RST;
        fail_hold_q    = HOLD_TIME_RST;
        confirm_q      = CONFIRM_RST;
        reader_ready_q = 1'b1;
        for (k = 0; k < 16; k++) begin
            card_used[k] = 1'b0;
            card_size[k] = 4'd0;
            card_low[k]  = 64'd0;
            card_high[k] = 16'd0;
        end
        card_used[0] = 1'b1;
        card_used[1] = 1'b1;
        card_size[0] = 4'd4;
        card_size[1] = 4'd4;
        card_low[0]  = CARD0_UID;
        card_low[1]  = CARD1_UID;
        state_q     = ST_IDLE;
        detect_cnt  = 4'd0;
        failure_cnt = 4'd0;
        feedback_dl = 32'd0;
        lockout_dl  = 32'd0;
    endtask

    // A stored card matches when the sizes are equal and the first
    // min(size, 10) bytes agree; bytes past the size are ignored.
    function automatic bit card_matches(int k, t_in_item p);
        logic [79:0] a;
        logic [79:0] b;
        int n;
        int i;
        if (card_size[k] != p.card_uid_size)
            return 1'b0;
        a = {card_high[k], card_low[k]};
        b = {p.card_uid_high, p.card_uid_low};
        n = (p.card_uid_size < 10) ? p.card_uid_size : 10;
        for (i = 0; i < n; i++)
            if (a[8*i +: 8] != b[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the copy of the controller by one poll and return the event it reports.
    function automatic t_out_item predict_poll(t_in_item p);
        t_out_item r;
        int k;
        r = '0;
        r.event_code = EV_NONE;
        r.slot_index = 5'h1F;
        if (!reader_ready_q)
            return r;
        if (!p.enable && state_q != ST_IDLE) begin
            // Disabling always drops back to idle and clears the counters.
            state_q     = ST_IDLE;
            detect_cnt  = 4'd0;
            failure_cnt = 4'd0;
            feedback_dl = p.now_time;
            lockout_dl  = p.now_time;
            return r;
        end
        case (state_q)
            ST_IDLE: begin
                if (p.enable) begin
                    detect_cnt  = 4'd0;
                    state_q     = ST_POLL;
                    feedback_dl = p.now_time;
                end
            end
            ST_POLL: begin
                if (p.card_ok) begin
                    if (detect_cnt < 4'd15)
                        detect_cnt++;
                    // A confirm count of zero behaves like one.
                    if (detect_cnt >= confirm_q) begin
                        detect_cnt  = 4'd0;
                        state_q     = ST_VERIFY;
                        feedback_dl = p.now_time;
                    end
                end else begin
                    detect_cnt = 4'd0;
                end
            end
            ST_VERIFY: begin
                if (!p.card_ok) begin
                    state_q     = ST_POLL;
                    feedback_dl = p.now_time;
                end else begin
                    r.uid_present  = 1'b1;
                    r.out_uid_size = p.card_uid_size;
                    r.out_uid_low  = p.card_uid_low;
                    r.out_uid_high = p.card_uid_high;
                    for (k = 0; k < 16; k++)
                        if (card_used[k] && card_matches(k, p))
                            break;
                    // In register mode an unknown card takes the first free slot.
                    if (k >= 16 && p.register_request) begin
                        for (k = 0; k < 16; k++)
                            if (!card_used[k])
                                break;
                        if (k < 16) begin
                            card_used[k] = 1'b1;
                            card_size[k] = p.card_uid_size;
                            card_low[k]  = p.card_uid_low;
                            card_high[k] = p.card_uid_high;
                        end
                    end
                    if (k < 16) begin
                        failure_cnt  = 4'd0;
                        state_q      = ST_OK_FB;
                        feedback_dl  = p.now_time + 32'(success_hold_q);
                        r.event_code = EV_SUCCESS;
                        r.slot_index = 5'(k);
                    end else begin
                        if (failure_cnt < 4'd15)
                            failure_cnt++;
                        if (failure_cnt >= fail_limit_q) begin
                            state_q      = ST_LOCK;
                            feedback_dl  = p.now_time;
                            lockout_dl   = p.now_time + 32'(lockout_time_q);
                            r.event_code = EV_LOCKOUT;
                        end else begin
                            state_q      = ST_FAIL_FB;
                            feedback_dl  = p.now_time + 32'(fail_hold_q);
                            r.event_code = EV_FAIL;
                        end
                    end
                end
            end
            ST_OK_FB, ST_FAIL_FB: begin
                // Deadlines compare as plain unsigned, wrap or not.
                if (p.now_time >= feedback_dl) begin
                    state_q     = ST_WAIT_REMOVE;
                    feedback_dl = p.now_time;
                end
            end
            ST_WAIT_REMOVE: begin
                if (!p.card_ok) begin
                    detect_cnt  = 4'd0;
                    state_q     = ST_POLL;
                    feedback_dl = p.now_time;
                end
            end
            ST_LOCK: begin
                if (p.now_time >= lockout_dl) begin
                    failure_cnt = 4'd0;
                    detect_cnt  = 4'd0;
                    state_q     = ST_POLL;
                    feedback_dl = p.now_time;
                end
            end
            default: begin
                state_q     = ST_IDLE;
                detect_cnt  = 4'd0;
                failure_cnt = 4'd0;
                feedback_dl = p.now_time;
                lockout_dl  = p.now_time;
            end
        endcase
        return r;
    endfunction

    // Remembers whether the item on the input was taken at the last rising edge.
    always @(posedge i_clk) begin
        in_taken <= i_valid && !o_stall;
    end

    // The driver presents the head of the queue at the falling edge. An
    // item not yet taken stays put, and valid never looks at the stall.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            i_valid <= 1'b1;
        end else if (poll_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            i_item  <= poll_queue.pop_front();
            i_valid <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // The monitor predicts on every accepted poll and checks every accepted
    // result at the rising edge. The watchdog counts edges where nothing moves.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_events.push_back(predict_poll(i_item));
                polls_sent++;
            end
            if (o_valid && !i_stall) begin
                events_seen++;
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result item: %p", o_item);
                end else begin
                    want = expected_events.pop_front();
                    if (o_item.event_code !== want.event_code
                        || o_item.uid_present !== want.uid_present
                        || o_item.slot_index !== want.slot_index
                        || o_item.out_uid_size !== want.out_uid_size
                        || o_item.out_uid_low !== want.out_uid_low
                        || o_item.out_uid_high !== want.out_uid_high) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result mismatch: expected %p, got %p", want, o_item);
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            // A verify moves nothing until its result leaves; a long stall run adds more idle edges.
            if (idle_cycles >= 20000 && !watchdog_hit) begin
                watchdog_hit = 1'b1;
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Writes one setting while the block is idle and mirrors it in the model.
    task automatic write_setting(logic [2:0] idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FAIL_LIMIT:   fail_limit_q   = value[3:0];
            CFG_LOCKOUT_TIME: lockout_time_q = value;
            CFG_SUCCESS_HOLD: success_hold_q = value;
            CFG_FAIL_HOLD:    fail_hold_q    = value;
            CFG_CONFIRM:      confirm_q      = value[3:0];
            default:          reader_ready_q = value[0];
        endcase
    endtask

    // Lets every queued poll go out and every result come back, plus slack.
    task automatic drain();
        wait (poll_queue.size() == 0 && !i_valid && expected_events.size() == 0);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic t_in_item make_poll(logic [31:0] now_ms, bit en, bit reg_req,
                                           bit present, logic [3:0] size,
                                           logic [63:0] low, logic [15:0] high);
        t_in_item p;
        p.now_time         = now_ms;
        p.enable           = en;
        p.register_request = reg_req;
        p.card_ok          = present;
        p.card_uid_size    = size;
        p.card_uid_low     = low;
        p.card_uid_high    = high;
        return p;
    endfunction

    // Random UIDs come mostly from a small pool, so known, registered and
    // near-miss cards all recur; the rest are fully random.
    function automatic t_in_item random_card(logic [31:0] now_ms, bit reg_req);
        logic [63:0] low;
        logic [15:0] high;
        logic [3:0]  size;
        int pick;
        pick = $urandom_range(9);
        low  = {$urandom, $urandom};
        high = 16'($urandom);
        size = 4'($urandom_range(15));
        if (pick < 3) begin
            size = 4'd4;
            low  = (pick == 0) ? CARD0_UID : CARD1_UID;
            low[63:32] = (pick == 2) ? $urandom : 32'd0;
            high = 16'd0;
        end else if (pick < 7) begin
            // A handful of repeatable cards that can be registered and read back.
            size = 4'(pick + 1);
            low  = 64'h1122_3344_5566_7700 | 64'(pick);
            high = 16'hA55A;
        end else if (pick == 7) begin
            size = 4'($urandom_range(10));
        end
        return make_poll(now_ms, 1'b1, reg_req, 1'b1, size, low, high);
    endfunction

    // One card session: enable, confirm, verify, feedback and removal,
    // with random times and an occasional broken step.
    task automatic queue_session(ref logic [31:0] clock_ms);
        int n;
        int i;
        bit reg_req;
        reg_req = ($urandom_range(3) == 0);
        n = $urandom_range(2, 8);
        poll_queue.push_back(make_poll(clock_ms, 1'b1, 1'b0, 1'b0, 4'd0, 64'd0, 16'd0));
        for (i = 0; i < n; i++) begin
            clock_ms += $urandom_range(1, 400);
            if ($urandom_range(15) == 0)
                poll_queue.push_back(make_poll(clock_ms, $urandom_range(7) != 0,
                                               1'($urandom), 1'($urandom), 4'($urandom),
                                               {$urandom, $urandom}, 16'($urandom)));
            else
                poll_queue.push_back(random_card(clock_ms, reg_req));
        end
        for (i = 0; i < 3; i++) begin
            clock_ms += $urandom_range(100, 3000);
            poll_queue.push_back(make_poll(clock_ms, 1'b1, 1'b0, $urandom_range(1) == 0,
                                           4'd0, 64'd0, 16'd0));
        end
    endtask

    initial begin
        logic [31:0] clock_ms;
        int ph;
        int s;
        mismatches    = 0;
        polls_sent    = 0;
        events_seen   = 0;
        idle_cycles   = 0;
        watchdog_hit  = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FAIL_LIMIT;
        i_cfg_data  = 16'd0;
        model_reset();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a preloaded card with bytes beyond the size, registration of
        // an unknown card, and disabling.
        poll_queue.push_back(make_poll(32'd0, 1'b1, 1'b0, 1'b0, 4'd0, 64'd0, 16'd0));
        poll_queue.push_back(make_poll(32'd1, 1'b1, 1'b0, 1'b1, 4'd4, CARD0_UID, 16'd0));
        poll_queue.push_back(make_poll(32'd2, 1'b1, 1'b0, 1'b1, 4'd4, CARD0_UID, 16'd0));
        poll_queue.push_back(make_poll(32'd3, 1'b1, 1'b0, 1'b1, 4'd4, CARD0_UID, 16'd0));
        poll_queue.push_back(make_poll(32'd4, 1'b1, 1'b0, 1'b1, 4'd4,
                                       CARD1_UID | 64'hFF00_0000_0000, 16'hFFFF));
        poll_queue.push_back(make_poll(32'd600, 1'b1, 1'b0, 1'b1, 4'd4, CARD1_UID, 16'd0));
        poll_queue.push_back(make_poll(32'd601, 1'b1, 1'b0, 1'b0, 4'd0, 64'd0, 16'd0));
        poll_queue.push_back(make_poll(32'd602, 1'b1, 1'b1, 1'b1, 4'd15, '1, 16'hFFFF));
        poll_queue.push_back(make_poll(32'd603, 1'b1, 1'b1, 1'b1, 4'd15, '1, 16'hFFFF));
        poll_queue.push_back(make_poll(32'd604, 1'b1, 1'b1, 1'b1, 4'd15, '1, 16'hFFFF));
        poll_queue.push_back(make_poll(32'd605, 1'b1, 1'b1, 1'b1, 4'd15, '1, 16'hFFFF));
        poll_queue.push_back(make_poll(32'd606, 1'b0, 1'b1, 1'b1, 4'd10, 64'd0, 16'd0));
        drain();

        // Lockout on the first failure with a time that wraps past 2^32.
        write_setting(CFG_FAIL_LIMIT, 16'd0);
        write_setting(CFG_CONFIRM, 16'd0);
        write_setting(CFG_LOCKOUT_TIME, 16'hFFFF);
        poll_queue.push_back(make_poll(32'hFFFF_FF00, 1'b1, 1'b0, 1'b0, 4'd0, 64'd0, 16'd0));
        poll_queue.push_back(make_poll(32'hFFFF_FF01, 1'b1, 1'b0, 1'b1, 4'd0, 64'd0, 16'd0));
        poll_queue.push_back(make_poll(32'hFFFF_FF02, 1'b1, 1'b0, 1'b1, 4'd0, 64'd0, 16'd0));
        poll_queue.push_back(make_poll(32'hFFFF_FF03, 1'b1, 1'b0, 1'b1, 4'd0, 64'd0, 16'd0));
        poll_queue.push_back(make_poll(32'h0000_0000, 1'b1, 1'b0, 1'b1, 4'd0, 64'd0, 16'd0));
        poll_queue.push_back(make_poll(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 4'd0, 64'd0, 16'd0));
        drain();

        // Reader not ready: every poll gives no event and changes nothing.
        write_setting(CFG_READER_READY, 16'd0);
        poll_queue.push_back(make_poll(32'd10, 1'b1, 1'b1, 1'b1, 4'd4, CARD0_UID, 16'd0));
        poll_queue.push_back(make_poll(32'd20, 1'b0, 1'b0, 1'b0, 4'd0, 64'd0, 16'd0));
        drain();
        write_setting(CFG_READER_READY, 16'd1);

        // Random sessions across several settings and idling phases.
        clock_ms = $urandom;
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            write_setting(CFG_FAIL_LIMIT, (ph == 2) ? 16'd15 : 16'($urandom_range(1, 4)));
            write_setting(CFG_CONFIRM, (ph == 5) ? 16'd15 : 16'($urandom_range(1, 4)));
            write_setting(CFG_LOCKOUT_TIME, (ph == 3) ? 16'hFFFF : 16'($urandom_range(0, 6000)));
            write_setting(CFG_SUCCESS_HOLD, (ph == 4) ? 16'd0 : 16'($urandom));
            write_setting(CFG_FAIL_HOLD, (ph == 6) ? 16'hFFFF : 16'($urandom_range(0, 2000)));
            for (s = 0; s < 21; s++) begin
                if ($urandom_range(9) == 0)
                    poll_queue.push_back(make_poll(clock_ms, 1'b0, 1'($urandom),
                                                   1'($urandom), 4'($urandom),
                                                   {$urandom, $urandom}, 16'($urandom)));
                queue_session(clock_ms);
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        $display("Sent %0d polls, checked %0d results over directed cases and eight phases",
                 polls_sent, events_seen);
        $display("of random card sessions with registration, lockout and wrapping time.");
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/calf_pkg.sv
rtl/core/calf_uid_cmp.sv
rtl/core/card_access_lockout_fsm.sv
tb/sv/tb_card_access_lockout_fsm.sv
